@@ src/video_ram_port_and_attribute_renderer_core_macros.svh @@
// Assertion macros for the video RAM port and attribute renderer.
`ifndef VIDEO_RAM_PORT_AND_ATTRIBUTE_RENDERER_CORE_MACROS_SVH
`define VIDEO_RAM_PORT_AND_ATTRIBUTE_RENDERER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VRAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define VRAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/vrar_pkg.sv @@
// Types and constants shared by the video RAM port and attribute renderer.
package vrar_pkg;

    localparam int VIDEO_DEPTH_DEF = 262144;
    localparam int ATTR_DEPTH      = 2048;
    localparam int GLYPH_DEPTH     = 2048;
    localparam int VADDR_W         = 18;

    localparam logic [3:0] ACT_CTRL    = 4'd0;
    localparam logic [3:0] ACT_LATCH   = 4'd1;
    localparam logic [3:0] ACT_INDEX   = 4'd2;
    localparam logic [3:0] ACT_REG     = 4'd3;
    localparam logic [3:0] ACT_READ    = 4'd4;
    localparam logic [3:0] ACT_STATUS  = 4'd5;
    localparam logic [3:0] ACT_ROW     = 4'd6;
    localparam logic [3:0] ACT_RENDER  = 4'd7;
    localparam logic [3:0] ACT_CHARGEN = 4'd8;

    localparam logic [4:0] IDX_ADDR_HI = 5'd18;
    localparam logic [4:0] IDX_ADDR_LO = 5'd19;
    localparam logic [4:0] IDX_PORT    = 5'd31;

    localparam logic [1:0] MODE_LORES = 2'd0;
    localparam logic [1:0] MODE_EXT   = 2'd1;
    localparam logic [1:0] MODE_THIN  = 2'd2;
    localparam logic [1:0] MODE_ALPHA = 2'd3;

    localparam logic [7:0] STATUS_ON  = 8'hff;
    localparam logic [7:0] STATUS_OFF = 8'hfe;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  data;
        logic [13:0] cell_address;
        logic [3:0]  row_line;
        logic        cursor_here;
        logic        display_enable;
        logic [10:0] rom_address;
    } in_t;

    typedef struct packed {
        logic [7:0] value;
        logic       from_render;
    } out_t;

endpackage

@@ src/video_ram_port_and_attribute_renderer_core.sv @@
// Video RAM port and character-cell pixel-row generator, top level.
// Render: a word is taken only in idle, then the attribute, video and glyph states follow.
// A render makes three dependent reads (attribute, video, glyph RAM), each into a register.
// Status reads and write actions finish in idle; data reads and index 31 with video selected
// first read the attribute RAM. The output register lets a new word in while a result waits.
// Reset clears the control registers and pointers; RAM contents stay undefined until written.
`include "video_ram_port_and_attribute_renderer_core_macros.svh"

module video_ram_port_and_attribute_renderer_core #(
    parameter int VIDEO_DEPTH = vrar_pkg::VIDEO_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  vrar_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vrar_pkg::out_t out_data
);
    import vrar_pkg::*;

    localparam int VAW = $clog2(VIDEO_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ATTR = 3'd1;
    localparam logic [2:0] S_VID  = 3'd2;
    localparam logic [2:0] S_GLY  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_RENDER = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [13:0] cell_reg, cell_next;
    logic [3:0]  ra_reg, ra_next;
    logic        curs_reg, curs_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  latch_reg, latch_next;
    logic [4:0]  index_reg, index_next;
    logic [13:0] alpha_reg, alpha_next;
    logic [17:0] graph_reg, graph_next;
    logic [15:0] blink_reg, blink_next;
    out_t        res_reg, res_next;
    out_t        out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [7:0]  attr_mem [ATTR_DEPTH];
    logic [7:0]  vid_mem [VIDEO_DEPTH];
    logic [7:0]  gly_mem [GLYPH_DEPTH];
    logic [7:0]  attr_q_reg, vid_q_reg, gly_q_reg;

    logic        attr_re, attr_we, vid_re, vid_we, gly_re, gly_we;
    logic [10:0] attr_raddr, attr_waddr, gly_raddr, gly_waddr;
    logic [7:0]  gly_wdata;
    logic [VADDR_W-1:0] vid_full_addr;
    logic [VAW-1:0]     vid_addr;
    logic [13:0] alpha_inc;
    logic        done, slot_free;
    out_t        res_now;

    function automatic logic [7:0] lores(input logic [7:0] chr, input logic [3:0] ra);
        logic hi_bit;
        logic lo_bit;
        begin
            if (ra <= 4'd2) begin
                hi_bit = chr[7];
                lo_bit = chr[3];
            end else if (ra <= 4'd5) begin
                hi_bit = chr[6];
                lo_bit = chr[2];
            end else if (ra <= 4'd8) begin
                hi_bit = chr[5];
                lo_bit = chr[1];
            end else begin
                hi_bit = chr[4];
                lo_bit = chr[0];
            end
            lores = {{5{hi_bit}}, {3{lo_bit}}};
        end
    endfunction

    function automatic logic [7:0] bit_flip(input logic [7:0] v);
        logic [7:0] r;
        begin
            for (int i = 0; i < 8; i++)
            begin
                r[7-i] = v[i];
            end
            bit_flip = r;
        end
    endfunction

    // Builds the pattern for the mode, then applies the attribute effects in priority order.
    function automatic logic [7:0] render_fx(input logic [7:0] attr, input logic [7:0] chr,
                                             input logic [7:0] glyph, input logic [3:0] ra,
                                             input logic curs, input logic [15:0] blink);
        logic [7:0] g;
        begin
            case (attr[1:0])
                MODE_LORES: g = lores(chr, ra);
                MODE_EXT:   g = bit_flip(chr);
                MODE_THIN:  g = 8'h00;
                MODE_ALPHA: g = glyph;
                default:    g = 8'h00;
            endcase
            if (attr[3] && ra == 4'd11) g = 8'hff;
            if (attr[2] && (ra == 4'd5 || ra == 4'd6)) g = 8'hff;
            if (attr[6] && blink[13]) g = 8'h00;
            if (attr[5]) g = 8'h00;
            if (curs && blink[14]) g = ~g;
            if (attr[4]) g = ~g;
            render_fx = g;
        end
    endfunction

    assign alpha_inc = alpha_reg + 14'd1;
    assign slot_free = !out_valid_reg || out_ready;
    assign vid_addr  = vid_full_addr[VAW-1:0];
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cell_next      = cell_reg;
        ra_next        = ra_reg;
        curs_next      = curs_reg;
        ctrl_next      = ctrl_reg;
        latch_next     = latch_reg;
        index_next     = index_reg;
        alpha_next     = alpha_reg;
        graph_next     = graph_reg;
        blink_next     = blink_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        attr_re        = 1'b0;
        attr_we        = 1'b0;
        vid_re         = 1'b0;
        vid_we         = 1'b0;
        gly_re         = 1'b0;
        gly_we         = 1'b0;
        attr_raddr     = alpha_reg[10:0];
        attr_waddr     = alpha_inc[10:0];
        gly_raddr      = {vid_q_reg[6:0], ra_reg};
        gly_waddr      = in_data.rom_address;
        gly_wdata      = in_data.data;
        vid_full_addr  = attr_q_reg[7] ? {4'b0, alpha_reg} : graph_reg;
        done           = 1'b0;
        res_now        = '{value: attr_q_reg, from_render: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.action)
                        ACT_CTRL:  ctrl_next = in_data.data;
                        ACT_LATCH: latch_next = in_data.data;
                        ACT_INDEX:
                        begin
                            index_next = in_data.data[4:0];
                            if (in_data.data[4:0] == IDX_PORT)
                            begin
                                alpha_next = alpha_inc;
                                graph_next = {alpha_inc, ctrl_reg[3:0]};
                                if (ctrl_reg[5])
                                begin
                                    // Video target depends on the attribute at the new address.
                                    attr_re    = 1'b1;
                                    attr_raddr = alpha_inc[10:0];
                                    op_next    = OP_WRITE;
                                    state_next = S_ATTR;
                                end
                                else
                                begin
                                    attr_we = 1'b1;
                                end
                            end
                        end
                        ACT_REG:
                        begin
                            if (index_reg == IDX_ADDR_HI)
                                alpha_next = {in_data.data[5:0], alpha_reg[7:0]};
                            else if (index_reg == IDX_ADDR_LO)
                                alpha_next = {alpha_reg[13:8], in_data.data};
                        end
                        ACT_READ:
                        begin
                            attr_re    = 1'b1;
                            op_next    = OP_READ;
                            state_next = S_ATTR;
                        end
                        ACT_STATUS:
                        begin
                            done    = 1'b1;
                            res_now = '{value: in_data.display_enable ? STATUS_ON : STATUS_OFF,
                                        from_render: 1'b0};
                        end
                        ACT_ROW: blink_next = blink_reg + 16'd1;
                        ACT_RENDER:
                        begin
                            attr_re    = 1'b1;
                            attr_raddr = in_data.cell_address[10:0];
                            cell_next  = in_data.cell_address;
                            ra_next    = in_data.row_line;
                            curs_next  = in_data.cursor_here;
                            op_next    = OP_RENDER;
                            state_next = S_ATTR;
                        end
                        ACT_CHARGEN: gly_we = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_ATTR:
            begin
                case (op_reg)
                    OP_WRITE:
                    begin
                        vid_we     = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_RENDER:
                    begin
                        vid_full_addr = attr_q_reg[7] ? {4'b0, cell_reg} : {cell_reg, ra_reg};
                        vid_re        = 1'b1;
                        state_next    = S_VID;
                    end
                    default:
                    begin
                        if (ctrl_reg[5])
                        begin
                            vid_re     = 1'b1;
                            state_next = S_VID;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                endcase
            end
            S_VID:
            begin
                if (op_reg == OP_RENDER)
                begin
                    gly_re     = 1'b1;
                    state_next = S_GLY;
                end
                else
                begin
                    done    = 1'b1;
                    res_now = '{value: vid_q_reg, from_render: 1'b0};
                end
            end
            S_GLY:
            begin
                done    = 1'b1;
                res_now = '{value: render_fx(attr_q_reg, vid_q_reg, gly_q_reg, ra_reg,
                                             curs_reg, blink_reg),
                            from_render: 1'b1};
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // A finished result goes straight to the output register when it is free.
        if (done)
        begin
            if (slot_free)
            begin
                out_next       = res_now;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = res_now;
                state_next = S_FIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_READ;
            ctrl_reg      <= '0;
            latch_reg     <= '0;
            index_reg     <= '0;
            alpha_reg     <= '0;
            graph_reg     <= '0;
            blink_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ctrl_reg      <= ctrl_next;
            latch_reg     <= latch_next;
            index_reg     <= index_next;
            alpha_reg     <= alpha_next;
            graph_reg     <= graph_next;
            blink_reg     <= blink_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        ra_reg   <= ra_next;
        curs_reg <= curs_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (attr_we)
            attr_mem[attr_waddr] <= latch_reg;
        if (attr_re)
            attr_q_reg <= attr_mem[attr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vid_we)
            vid_mem[vid_addr] <= latch_reg;
        if (vid_re)
            vid_q_reg <= vid_mem[vid_addr];
    end

    always_ff @(posedge clk)
    begin
        if (gly_we)
            gly_mem[gly_waddr] <= gly_wdata;
        if (gly_re)
            gly_q_reg <= gly_mem[gly_raddr];
    end

    `VRAR_ASSERT_NEXT(a_render_enters_attr,
        in_valid && in_ready && in_data.action == ACT_RENDER,
        state_reg == S_ATTR && op_reg == OP_RENDER,
        "render word did not start the attribute fetch")
    `VRAR_ASSERT_NEXT(a_simple_stays_idle,
        in_valid && in_ready && (in_data.action == ACT_CTRL || in_data.action == ACT_LATCH ||
        in_data.action == ACT_REG || in_data.action == ACT_ROW ||
        in_data.action == ACT_CHARGEN),
        in_ready,
        "single-cycle action left the port busy")
    `VRAR_ASSERT_NOW(a_fin_needs_blocked_output,
        state_reg == S_FIN,
        out_valid_reg,
        "result parked although the output register was empty")

endmodule

@@ bench/video_ram_port_and_attribute_renderer_core_test.sv @@
// Testbench for the video RAM port and attribute renderer core.
`timescale 1ns / 100ps

module video_ram_port_and_attribute_renderer_core_test;
    import vrar_pkg::*;

    localparam int IDLE_PCT      = 13;
    localparam int HOLD_AT       = 30;
    localparam int HOLD_LEN      = 400;
    localparam int SEGMENTS      = 9;
    localparam int SEGMENT_WORDS = 115;
    localparam int DRAIN_CYCLES  = 16;
    // About a thousand words, plus sender gaps and receiver stalls,
    // stays far below this.
    localparam int CYCLE_LIMIT   = 100000;

    localparam int CTRL_VIDEO      = 5;
    localparam int ATTR_STRIKE     = 2;
    localparam int ATTR_UNDERLINE  = 3;
    localparam int ATTR_REVERSE    = 4;
    localparam int ATTR_BLANK      = 5;
    localparam int ATTR_FLASH      = 6;
    localparam int ATTR_ALPHA_ADDR = 7;

    localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [3:0] ACT_UNUSED_HI = 4'd15;
    localparam logic [4:0] IDX_OTHER     = 5'd5;

    typedef struct packed {
        in_t  word;
        logic yields;
        out_t result;
    } bus_job_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // Shadow of the block's registers and memories.
    logic [7:0]  ctrl_byte   = '0;
    logic [7:0]  latch_byte  = '0;
    logic [4:0]  reg_index   = '0;
    logic [13:0] alpha_ptr   = '0;
    logic [17:0] gfx_ptr     = '0;
    logic [15:0] blink_count = '0;
    logic [7:0]  attr_mem  [ATTR_DEPTH];
    bit          attr_known[ATTR_DEPTH];
    logic [7:0]  video_mem  [VIDEO_DEPTH_DEF];
    bit          video_known[VIDEO_DEPTH_DEF];
    logic [7:0]  glyph_mem  [GLYPH_DEPTH];
    bit          glyph_known[GLYPH_DEPTH];

    bus_job_t    bus_words[$];
    out_t        awaited_outputs[$];
    logic [17:0] prepared_cells[$];
    int unsigned action_count[16];
    int unsigned busy_words    = 0;
    int unsigned words_sent    = 0;
    int unsigned steady_from   = 0;
    int unsigned steady_to     = 0;
    int unsigned results_seen  = 0;
    int unsigned hold_cycles   = 0;
    bit          held          = 1'b0;
    int unsigned failures      = 0;
    int unsigned cycle_count   = 0;
    wire         steady = (words_sent >= steady_from) && (words_sent < steady_to);

    video_ram_port_and_attribute_renderer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [17:0] port_video_index();
        if (attr_mem[alpha_ptr[10:0]][ATTR_ALPHA_ADDR])
            return {4'b0, alpha_ptr};
        return gfx_ptr;
    endfunction

    function automatic logic [17:0] char_index(logic [7:0] attr, logic [13:0] ca,
                                               logic [3:0] line);
        return attr[ATTR_ALPHA_ADDR] ? {4'b0, ca} : {ca, line};
    endfunction

    function automatic logic [7:0] lores_pattern(logic [7:0] chr, logic [3:0] line);
        int hi;
        logic [7:0] pix;
        // Lines 0-2, 3-5 and 6-8 each show one pair of character bits; lines 9-15 show the last pair.
        hi = (line <= 2) ? 7 : (line <= 5) ? 6 : (line <= 8) ? 5 : 4;
        pix = '0;
        if (chr[hi])
            pix[7:3] = 5'h1f;
        if (chr[hi - 4])
            pix[2:0] = 3'h7;
        return pix;
    endfunction

    function automatic logic [7:0] render_pattern(logic [13:0] ca, logic [3:0] line,
                                                  logic cursor);
        logic [7:0] attr;
        logic [7:0] chr;
        logic [7:0] pix;
        attr = attr_mem[ca[10:0]];
        chr = video_mem[char_index(attr, ca, line)];
        case (attr[1:0])
            MODE_LORES: pix = lores_pattern(chr, line);
            MODE_EXT:   for (int i = 0; i < 8; i++) pix[7 - i] = chr[i];
            MODE_THIN:  pix = '0;
            default:    pix = glyph_mem[{chr[6:0], line}];
        endcase
        if (attr[ATTR_UNDERLINE] && line == 11)
            pix = 8'hff;
        if (attr[ATTR_STRIKE] && (line == 5 || line == 6))
            pix = 8'hff;
        if (attr[ATTR_FLASH] && blink_count[13])
            pix = '0;
        if (attr[ATTR_BLANK])
            pix = '0;
        if (cursor && blink_count[14])
            pix = ~pix;
        if (attr[ATTR_REVERSE])
            pix = ~pix;
        return pix;
    endfunction

    // True when the word would read a memory entry that was never written.
    function automatic bit touches_unwritten(in_t w);
        logic [13:0] next_alpha;
        logic [7:0]  attr;
        logic [17:0] vi;
        case (w.action)
            ACT_READ:
            begin
                if (!attr_known[alpha_ptr[10:0]])
                    return 1'b1;
                return ctrl_byte[CTRL_VIDEO] && !video_known[port_video_index()];
            end
            ACT_INDEX:
            begin
                next_alpha = alpha_ptr + 14'd1;
                return w.data[4:0] == IDX_PORT && ctrl_byte[CTRL_VIDEO]
                       && !attr_known[next_alpha[10:0]];
            end
            ACT_RENDER:
            begin
                if (!attr_known[w.cell_address[10:0]])
                    return 1'b1;
                attr = attr_mem[w.cell_address[10:0]];
                vi = char_index(attr, w.cell_address, w.row_line);
                if (!video_known[vi])
                    return 1'b1;
                return attr[1:0] == MODE_ALPHA
                       && !glyph_known[{video_mem[vi][6:0], w.row_line}];
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic apply_bus_word(in_t w, output logic yields, output out_t res);
        logic [17:0] vi;
        yields = 1'b0;
        res = '0;
        case (w.action)
            ACT_CTRL:  ctrl_byte = w.data;
            ACT_LATCH: latch_byte = w.data;
            ACT_INDEX:
            begin
                reg_index = w.data[4:0];
                if (reg_index == IDX_PORT)
                begin
                    alpha_ptr = alpha_ptr + 14'd1;
                    gfx_ptr = {alpha_ptr, ctrl_byte[3:0]};
                    if (ctrl_byte[CTRL_VIDEO])
                    begin
                        vi = port_video_index();
                        video_mem[vi] = latch_byte;
                        video_known[vi] = 1'b1;
                    end
                    else
                    begin
                        attr_mem[alpha_ptr[10:0]] = latch_byte;
                        attr_known[alpha_ptr[10:0]] = 1'b1;
                    end
                end
            end
            ACT_REG:
            begin
                if (reg_index == IDX_ADDR_HI)
                    alpha_ptr = {w.data[5:0], alpha_ptr[7:0]};
                else if (reg_index == IDX_ADDR_LO)
                    alpha_ptr[7:0] = w.data;
            end
            ACT_READ:
            begin
                yields = 1'b1;
                res.value = ctrl_byte[CTRL_VIDEO] ? video_mem[port_video_index()]
                                                  : attr_mem[alpha_ptr[10:0]];
            end
            ACT_STATUS:
            begin
                yields = 1'b1;
                res.value = w.display_enable ? STATUS_ON : STATUS_OFF;
            end
            ACT_ROW: blink_count = blink_count + 16'd1;
            ACT_RENDER:
            begin
                yields = 1'b1;
                res.value = render_pattern(w.cell_address, w.row_line, w.cursor_here);
                res.from_render = 1'b1;
            end
            ACT_CHARGEN:
            begin
                glyph_mem[w.rom_address] = w.data;
                glyph_known[w.rom_address] = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic in_t random_word(logic [3:0] act);
        in_t w;
        w.action = act;
        w.data = 8'($urandom_range(255));
        w.cell_address = 14'($urandom_range(16383));
        w.row_line = 4'($urandom_range(15));
        w.cursor_here = 1'($urandom_range(1));
        w.display_enable = 1'($urandom_range(1));
        w.rom_address = 11'($urandom_range(2047));
        return w;
    endfunction

    // Queue a word with its expected output; a word that would read unwritten
    // memory is dropped.
    task automatic plan(in_t w);
        bus_job_t job;
        if (touches_unwritten(w))
            return;
        job.word = w;
        apply_bus_word(w, job.yields, job.result);
        bus_words.push_back(job);
        action_count[w.action]++;
        if (w.action <= ACT_CHARGEN)
            busy_words++;
    endtask

    task automatic send_action(logic [3:0] act, logic [7:0] payload);
        in_t w;
        w = random_word(act);
        w.data = payload;
        plan(w);
    endtask

    task automatic select_index(logic [4:0] idx);
        logic [2:0] junk;
        junk = 3'($urandom_range(7));
        send_action(ACT_INDEX, {junk, idx});
    endtask

    task automatic load_alpha(logic [13:0] a);
        logic [1:0] junk;
        junk = 2'($urandom_range(3));
        select_index(IDX_ADDR_HI);
        send_action(ACT_REG, {junk, a[13:8]});
        select_index(IDX_ADDR_LO);
        send_action(ACT_REG, a[7:0]);
    endtask

    // Store one byte through the port; the pointer lands on target.
    task automatic port_store(logic [13:0] target, logic to_video, logic [3:0] low,
                              logic [7:0] val);
        logic [7:0] ctrl;
        ctrl = 8'($urandom_range(255));
        ctrl[CTRL_VIDEO] = to_video;
        ctrl[3:0] = low;
        send_action(ACT_CTRL, ctrl);
        send_action(ACT_LATCH, val);
        load_alpha(target - 14'd1);
        select_index(IDX_PORT);
    endtask

    task automatic render_at(logic [13:0] ca, logic [3:0] line);
        in_t w;
        w = random_word(ACT_RENDER);
        w.cell_address = ca;
        w.row_line = line;
        plan(w);
    endtask

    // Write attribute, character and glyph row for one cell, then render it.
    task automatic prepare_cell(logic [13:0] ca, logic [3:0] line, logic [7:0] attr,
                                logic [7:0] chr);
        in_t w;
        port_store(ca, 1'b0, 4'($urandom_range(15)), attr);
        port_store(ca, 1'b1, attr[ATTR_ALPHA_ADDR] ? 4'($urandom_range(15)) : line, chr);
        if (attr[1:0] == MODE_ALPHA)
        begin
            w = random_word(ACT_CHARGEN);
            w.rom_address = {chr[6:0], line};
            plan(w);
        end
        if ($urandom_range(1))
            send_action(ACT_READ, 8'($urandom_range(255)));
        render_at(ca, line);
        prepared_cells.push_back({ca, line});
    endtask

    task automatic random_scenario();
        int unsigned pick;
        logic [13:0] ca;
        logic [7:0]  attr;
        logic [17:0] spot;
        in_t w;
        pick = $urandom_range(99);
        if (pick < 30 || prepared_cells.size() == 0)
        begin
            case ($urandom_range(9))
                0:       ca = '0;
                1:       ca = '1;
                default: ca = 14'($urandom_range(16383));
            endcase
            attr = 8'($urandom_range(255));
            // Blank and flash hide the pattern, so they are kept rarer.
            if ($urandom_range(3) != 0)
                attr[6:5] = 2'b00;
            prepare_cell(ca, 4'($urandom_range(15)), attr, 8'($urandom_range(255)));
        end
        else if (pick < 55)
        begin
            spot = prepared_cells[$urandom_range(prepared_cells.size() - 1)];
            w = random_word(ACT_RENDER);
            w.cell_address = spot[17:4];
            if ($urandom_range(1) == 0 || touches_unwritten(w))
                w.row_line = spot[3:0];
            plan(w);
        end
        else if (pick < 65)
        begin
            if ($urandom_range(1))
                send_action(ACT_CTRL, 8'($urandom_range(255)));
            send_action(ACT_READ, 8'($urandom_range(255)));
        end
        else if (pick < 75)
        begin
            send_action(ACT_STATUS, 8'($urandom_range(255)));
            repeat ($urandom_range(3)) send_action(ACT_ROW, 8'($urandom_range(255)));
        end
        else if (pick < 80)
            send_action(ACT_CHARGEN, 8'($urandom_range(255)));
        else if (pick < 85)
        begin
            send_action(ACT_INDEX, 8'($urandom_range(255)));
            send_action(ACT_REG, 8'($urandom_range(255)));
        end
        else if (pick < 90)
        begin
            case ($urandom_range(2))
                0:       send_action(4'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO)),
                                     8'($urandom_range(255)));
                1:       send_action(ACT_LATCH, 8'($urandom_range(255)));
                default: send_action(ACT_CTRL, 8'($urandom_range(255)));
            endcase
        end
        else
        begin
            port_store(14'($urandom_range(16383)), 1'($urandom_range(1)),
                       4'($urandom_range(15)), 8'($urandom_range(255)));
            if ($urandom_range(1))
                send_action(ACT_READ, 8'($urandom_range(255)));
        end
    endtask

    // Sender: offers queued words, holding each until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                if (bus_words[0].yields)
                    awaited_outputs.push_back(bus_words[0].result);
                void'(bus_words.pop_front());
                words_sent <= words_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (bus_words.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    in_data <= bus_words[0].word;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each output word and stalls at random, once for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (awaited_outputs.size() == 0)
                begin
                    $error("output word with nothing pending: value %h, from_render %b",
                           out_data.value, out_data.from_render);
                    failures++;
                end
                else
                begin
                    want = awaited_outputs.pop_front();
                    if (out_data.value !== want.value)
                    begin
                        $error("value: expected %h, got %h", want.value, out_data.value);
                        failures++;
                    end
                    if (out_data.from_render !== want.from_render)
                    begin
                        $error("from_render: expected %b, got %b",
                               want.from_render, out_data.from_render);
                        failures++;
                    end
                end
            end
            if (hold_cycles != 0)
                hold_cycles--;
            else if (!held && results_seen >= HOLD_AT)
            begin
                held = 1'b1;
                hold_cycles = HOLD_LEN;
            end
            out_ready <= hold_cycles == 0 && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d words unsent and %0d outputs outstanding.",
                     bus_words.size(), awaited_outputs.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_t w;
        int unsigned target;
        // Status with display enable on and off, unused codes, a dead register write.
        w = random_word(ACT_STATUS);
        w.display_enable = 1'b1;
        plan(w);
        w.display_enable = 1'b0;
        plan(w);
        send_action(ACT_UNUSED_LO, 8'h00);
        send_action(ACT_UNUSED_HI, 8'hff);
        select_index(IDX_OTHER);
        send_action(ACT_REG, 8'hff);
        // Glyph memory at both ends.
        w = random_word(ACT_CHARGEN);
        w.rom_address = '0;
        w.data = 8'h00;
        plan(w);
        w.rom_address = '1;
        w.data = 8'hff;
        plan(w);
        // The port pointer wraps from the top of its range to cell zero.
        port_store(14'h0000, 1'b0, 4'h0, {1'b1, 5'b0, MODE_LORES});
        port_store(14'h0000, 1'b1, 4'hf, 8'hff);
        send_action(ACT_READ, 8'h00);
        render_at(14'h0000, 4'h0);

        // Random scenarios in segments; one segment runs with no idling on either side.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 3)
                steady_from = bus_words.size();
            target = busy_words + SEGMENT_WORDS;
            while (busy_words < target)
                random_scenario();
            if (seg == 3)
                steady_to = bus_words.size();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (bus_words.size() != 0 || awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Compared %0d output words from %0d bus words: %0d renders, %0d reads, %0d %s",
                 results_seen, words_sent, action_count[ACT_RENDER], action_count[ACT_READ],
                 action_count[ACT_STATUS], "status reads.");
        $display("%0d row starts stepped the blink counter; %0d cells were set up.",
                 action_count[ACT_ROW], prepared_cells.size());
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
